### rtl/secded_72_64_encode_correct_macros.svh
// ----------------------------------------------------------------------------
// SECDED (72,64) assertion macros
// Shared property forms for the encoder/corrector checks.
// ----------------------------------------------------------------------------
`ifndef SECDED_72_64_ENCODE_CORRECT_MACROS_SVH
`define SECDED_72_64_ENCODE_CORRECT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SECDED_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SECDED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/secded_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SECDED (72,64) package
// Check matrix columns, action and status codes, shared types.
// ----------------------------------------------------------------------------
package secded_pkg;

    localparam int unsigned NUM_DATA_BITS  = 64;
    localparam int unsigned NUM_CHECK_BITS = 8;
    localparam int unsigned POS_W          = 7;

    // Column of the most significant check position; the others shift right.
    localparam logic [NUM_CHECK_BITS-1:0] CHECK_COL_MSB = 8'h80;

    localparam logic ACTION_ENCODE = 1'b0;
    localparam logic ACTION_CHECK  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_CORRECTED     = 2'd1,
        STATUS_UNCORRECTABLE = 2'd2
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [POS_W-1:0]     error_position;
    } corr_info_t;

    // Odd-weight columns of data positions 1..64, position 1 first.
    localparam logic [7:0] DATA_COLUMN [NUM_DATA_BITS] = '{
          8'd7,   8'd11,  8'd13,  8'd14,  8'd19,  8'd21,  8'd22,  8'd25,
          8'd26,  8'd28,  8'd31,  8'd35,  8'd37,  8'd38,  8'd41,  8'd42,
          8'd44,  8'd47,  8'd49,  8'd50,  8'd52,  8'd55,  8'd56,  8'd59,
          8'd61,  8'd62,  8'd67,  8'd69,  8'd70,  8'd73,  8'd74,  8'd76,
          8'd79,  8'd81,  8'd82,  8'd84,  8'd87,  8'd88,  8'd91,  8'd93,
          8'd94,  8'd97,  8'd98,  8'd100, 8'd103, 8'd104, 8'd107, 8'd109,
          8'd110, 8'd112, 8'd115, 8'd117, 8'd118, 8'd121, 8'd122, 8'd124,
          8'd127, 8'd131, 8'd133, 8'd134, 8'd137, 8'd138, 8'd140, 8'd143
    };

    // Data bits that feed check bit j; position p+1 sits at data bit 63-p.
    function automatic logic [NUM_DATA_BITS-1:0] row_mask(input int unsigned j);
        logic [NUM_DATA_BITS-1:0] m;
        m = '0;
        for (int unsigned p = 0; p < NUM_DATA_BITS; p++) begin
            m[NUM_DATA_BITS-1-p] = DATA_COLUMN[p][j];
        end
        return m;
    endfunction

endpackage

### rtl/secded_parity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SECDED parity tree
// XOR of the matrix columns of all set data bits, one tree per check bit.
// ----------------------------------------------------------------------------
module secded_parity
    import secded_pkg::*;
(
    input  logic [NUM_DATA_BITS-1:0]  data,
    output logic [NUM_CHECK_BITS-1:0] parity
);

    for (genvar j = 0; j < NUM_CHECK_BITS; j++) begin : g_row
        localparam logic [NUM_DATA_BITS-1:0] MASK = row_mask(j);
        assign parity[j] = ^(data & MASK);
    end

endmodule

### rtl/secded_correct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SECDED corrector
// Match the syndrome against every column, flip the hit bit, report status.
// ----------------------------------------------------------------------------
module secded_correct
    import secded_pkg::*;
(
    input  logic [NUM_DATA_BITS-1:0]  data,
    input  logic [NUM_CHECK_BITS-1:0] check,
    input  logic [NUM_CHECK_BITS-1:0] syndrome,
    output logic [NUM_DATA_BITS-1:0]  data_fixed,
    output logic [NUM_CHECK_BITS-1:0] check_fixed,
    output corr_info_t                info
);

    logic [NUM_DATA_BITS-1:0]  data_flip;
    logic [NUM_CHECK_BITS-1:0] check_flip;
    logic [POS_W-1:0]          pos;

    // Columns are distinct, so at most one compare hits; OR the positions.
    always_comb
    begin
        data_flip  = '0;
        check_flip = '0;
        pos        = '0;
        for (int unsigned p = 0; p < NUM_DATA_BITS; p++) begin
            if (syndrome == DATA_COLUMN[p])
            begin
                data_flip[NUM_DATA_BITS-1-p] = 1'b1;
                pos = pos | POS_W'(p + 1);
            end
        end
        for (int unsigned q = 0; q < NUM_CHECK_BITS; q++) begin
            if (syndrome == (CHECK_COL_MSB >> q))
            begin
                check_flip[NUM_CHECK_BITS-1-q] = 1'b1;
                pos = pos | POS_W'(NUM_DATA_BITS + q + 1);
            end
        end
    end

    always_comb
    begin
        data_fixed          = data ^ data_flip;
        check_fixed         = check ^ check_flip;
        info.error_position = pos;
        if (syndrome == '0)
            info.status = STATUS_OK;
        else if ((|data_flip) || (|check_flip))
            info.status = STATUS_CORRECTED;
        else
            info.status = STATUS_UNCORRECTABLE;
    end

endmodule

### rtl/secded_72_64_encode_correct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SECDED (72,64) encoder and corrector
// Encodes 64 data bits into 8 check bits, or checks and corrects a codeword.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  command   | start in, busy out   | action, data_word, check_bits
//  result    | done out (strobe)    | data_out, check_out, status,
//            |                      | error_position, syndrome
//
//  One item per cycle; each result follows its start through two registers.
//  The input register feeds the parity trees and column compares, which
//  settle into the result register; those two registers set the latency.
//  busy stays low: there is nothing to stall, and the result side has no
//  backpressure. Reset clears the valid flags only.
// ----------------------------------------------------------------------------
`include "secded_72_64_encode_correct_macros.svh"

module secded_72_64_encode_correct
    import secded_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      action,
    input  logic [NUM_DATA_BITS-1:0]  data_word,
    input  logic [NUM_CHECK_BITS-1:0] check_bits,
    output logic                      done,
    output logic [NUM_DATA_BITS-1:0]  data_out,
    output logic [NUM_CHECK_BITS-1:0] check_out,
    output logic [1:0]                status,
    output logic [POS_W-1:0]          error_position,
    output logic [NUM_CHECK_BITS-1:0] syndrome
);

    logic                      in_valid_reg;
    logic                      action_reg;
    logic [NUM_DATA_BITS-1:0]  data_reg;
    logic [NUM_CHECK_BITS-1:0] check_reg;

    logic [NUM_CHECK_BITS-1:0] parity;
    logic [NUM_CHECK_BITS-1:0] syn_next;
    logic [NUM_CHECK_BITS-1:0] check_sel;
    logic [NUM_DATA_BITS-1:0]  data_next;
    logic [NUM_CHECK_BITS-1:0] check_next;
    corr_info_t                info_next;

    logic                      done_reg;
    logic [NUM_DATA_BITS-1:0]  data_out_reg;
    logic [NUM_CHECK_BITS-1:0] check_out_reg;
    corr_info_t                info_reg;
    logic [NUM_CHECK_BITS-1:0] syndrome_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            action_reg <= action;
            data_reg   <= data_word;
            check_reg  <= check_bits;
        end
    end

    secded_parity u_parity (
        .data   (data_reg),
        .parity (parity)
    );

    // Encode runs with a zero syndrome so the corrector passes the new check byte.
    assign syn_next  = (action_reg == ACTION_CHECK) ? (parity ^ check_reg) : '0;
    assign check_sel = (action_reg == ACTION_CHECK) ? check_reg : parity;

    secded_correct u_correct (
        .data        (data_reg),
        .check       (check_sel),
        .syndrome    (syn_next),
        .data_fixed  (data_next),
        .check_fixed (check_next),
        .info        (info_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            data_out_reg  <= data_next;
            check_out_reg <= check_next;
            info_reg      <= info_next;
            syndrome_reg  <= syn_next;
        end
    end

    assign done           = done_reg;
    assign data_out       = data_out_reg;
    assign check_out      = check_out_reg;
    assign status         = info_reg.status;
    assign error_position = info_reg.error_position;
    assign syndrome       = syndrome_reg;

    `SECDED_ASSERT_NEXT(a_start_to_stage, start, in_valid_reg, "accepted item did not enter stage")
    `SECDED_ASSERT_NEXT(a_stage_to_done, in_valid_reg, done, "staged item produced no result")
    `SECDED_ASSERT_SAME(a_zero_syn_ok, done && (syndrome == '0), (status == STATUS_OK) && (error_position == '0), "zero syndrome not clean")
    `SECDED_ASSERT_SAME(a_corr_pos, done && (status == STATUS_CORRECTED), (error_position != '0) && (syndrome != '0), "corrected item lacks position")

endmodule

### tb/secded_72_64_encode_correct_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SECDED (72,64) encoder/corrector testbench
// A queue of commands feeds a clocked driver. A clocked monitor predicts each
// accepted item from the check matrix and compares every result field with
// the oldest expectation. A directed set covers encode, clean words, single
// errors at both ends of the data and check fields, double errors and
// syndromes that match no column. The random part is mostly valid codewords
// with zero, one or two flipped bits, under several sender idle rates.
// ----------------------------------------------------------------------------
module secded_72_64_encode_correct_test;
    import secded_pkg::*;

    typedef struct {
        logic                      act;
        logic [NUM_DATA_BITS-1:0]  data;
        logic [NUM_CHECK_BITS-1:0] chk;
        int unsigned               idle_pct;
    } ecc_cmd_t;

    typedef struct {
        logic [NUM_DATA_BITS-1:0]  data_out;
        logic [NUM_CHECK_BITS-1:0] check_out;
        status_t                   status;
        logic [POS_W-1:0]          error_position;
        logic [NUM_CHECK_BITS-1:0] syndrome;
    } ecc_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      action;
    logic [NUM_DATA_BITS-1:0]  data_word;
    logic [NUM_CHECK_BITS-1:0] check_bits;
    logic                      done;
    logic [NUM_DATA_BITS-1:0]  data_out;
    logic [NUM_CHECK_BITS-1:0] check_out;
    logic [1:0]                status;
    logic [POS_W-1:0]          error_position;
    logic [NUM_CHECK_BITS-1:0] syndrome;

    ecc_cmd_t    pending_cmds[$];
    ecc_result_t expected_words[$];
    ecc_result_t oldest_word;
    int unsigned mismatches;

    secded_72_64_encode_correct dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .data_word      (data_word),
        .check_bits     (check_bits),
        .done           (done),
        .data_out       (data_out),
        .check_out      (check_out),
        .status         (status),
        .error_position (error_position),
        .syndrome       (syndrome)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // XOR of the matrix columns of all set data bits; position p+1 is bit 63-p.
    function automatic logic [NUM_CHECK_BITS-1:0] check_byte_of(logic [NUM_DATA_BITS-1:0] d);
        logic [NUM_CHECK_BITS-1:0] acc;
        acc = '0;
        for (int p = 0; p < NUM_DATA_BITS; p++)
        begin
            if (d[NUM_DATA_BITS-1-p])
                acc ^= DATA_COLUMN[p];
        end
        return acc;
    endfunction

    function automatic ecc_result_t predict_word(logic act, logic [NUM_DATA_BITS-1:0] d,
                                                 logic [NUM_CHECK_BITS-1:0] c);
        ecc_result_t r;
        logic [NUM_CHECK_BITS-1:0] syn;
        r.data_out       = d;
        r.status         = STATUS_OK;
        r.error_position = '0;
        r.syndrome       = '0;
        if (act == ACTION_ENCODE)
        begin
            r.check_out = check_byte_of(d);
        end
        else
        begin
            syn         = check_byte_of(d) ^ c;
            r.check_out = c;
            r.syndrome  = syn;
            if (syn != '0)
            begin
                r.status = STATUS_UNCORRECTABLE;
                for (int p = 0; p < NUM_DATA_BITS; p++)
                begin
                    if (DATA_COLUMN[p] == syn)
                    begin
                        r.data_out[NUM_DATA_BITS-1-p] = ~r.data_out[NUM_DATA_BITS-1-p];
                        r.error_position = POS_W'(p + 1);
                        r.status         = STATUS_CORRECTED;
                    end
                end
                for (int q = 0; q < NUM_CHECK_BITS; q++)
                begin
                    if ((CHECK_COL_MSB >> q) == syn)
                    begin
                        r.check_out[NUM_CHECK_BITS-1-q] = ~r.check_out[NUM_CHECK_BITS-1-q];
                        r.error_position = POS_W'(NUM_DATA_BITS + q + 1);
                        r.status         = STATUS_CORRECTED;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $realtime, name, exp_v, got_v);
        end
    endfunction

    // Codeword {data, check}: position p sits at bit 72-p.
    function automatic logic [71:0] flip_position(logic [71:0] cw, int unsigned p);
        return cw ^ (72'd1 << (72 - p));
    endfunction

    task automatic queue_cmd(logic act, logic [71:0] cw, int unsigned idle_pct);
        ecc_cmd_t c;
        c.act      = act;
        c.data     = cw[71:8];
        c.chk      = cw[7:0];
        c.idle_pct = idle_pct;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [71:0] valid_codeword(logic [NUM_DATA_BITS-1:0] d);
        return {d, check_byte_of(d)};
    endfunction

    // Driver: present the next item once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            action     <= ACTION_ENCODE;
            data_word  <= '0;
            check_bits <= '0;
        end
        else if (!start || !busy)
        begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= pending_cmds[0].idle_pct)
            begin
                action     <= pending_cmds[0].act;
                data_word  <= pending_cmds[0].data;
                check_bits <= pending_cmds[0].chk;
                start      <= 1'b1;
                void'(pending_cmds.pop_front());
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check the result strobe, then record the item taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, data_out %h check_out %h",
                             $realtime, data_out, check_out);
                end
                else
                begin
                    oldest_word = expected_words.pop_front();
                    compare_field("data_out", oldest_word.data_out, data_out);
                    compare_field("check_out", 64'(oldest_word.check_out), 64'(check_out));
                    compare_field("status", 64'(oldest_word.status), 64'(status));
                    compare_field("error_position", 64'(oldest_word.error_position),
                                  64'(error_position));
                    compare_field("syndrome", 64'(oldest_word.syndrome), 64'(syndrome));
                end
            end
            if (start && !busy)
                expected_words.push_back(predict_word(action, data_word, check_bits));
        end
    end

    initial
    begin
        logic [71:0]  cw;
        int unsigned  idle_pct;
        int unsigned  kind;
        int unsigned  p1;
        int unsigned  p2;
        bit           no_idle;

        mismatches = 0;
        rst_n      = 1'b0;

        // Directed: encode extremes, check_bits ignored on encode.
        queue_cmd(ACTION_ENCODE, 72'h0, 0);
        queue_cmd(ACTION_ENCODE, {64'hFFFF_FFFF_FFFF_FFFF, 8'hFF}, 0);
        queue_cmd(ACTION_ENCODE, {64'h8000_0000_0000_0000, 8'h5A}, 0);
        queue_cmd(ACTION_ENCODE, {64'h0000_0000_0000_0001, 8'hA5}, 0);
        // Clean codewords pass through.
        queue_cmd(ACTION_CHECK, valid_codeword(64'h0), 0);
        queue_cmd(ACTION_CHECK, valid_codeword(64'hFFFF_FFFF_FFFF_FFFF), 0);
        queue_cmd(ACTION_CHECK, {64'hFFFF_FFFF_FFFF_FFFF, 8'hFF}, 0);
        // Single errors at the ends of the data and check fields.
        cw = valid_codeword(64'h0123_4567_89AB_CDEF);
        queue_cmd(ACTION_CHECK, flip_position(cw, 1), 0);
        queue_cmd(ACTION_CHECK, flip_position(cw, 32), 0);
        queue_cmd(ACTION_CHECK, flip_position(cw, 64), 0);
        queue_cmd(ACTION_CHECK, flip_position(cw, 65), 0);
        queue_cmd(ACTION_CHECK, flip_position(cw, 72), 0);
        // Double errors: data+data, check+check, data+check.
        queue_cmd(ACTION_CHECK, flip_position(flip_position(cw, 1), 2), 0);
        queue_cmd(ACTION_CHECK, flip_position(flip_position(cw, 65), 72), 0);
        queue_cmd(ACTION_CHECK, flip_position(flip_position(cw, 40), 70), 0);
        // Syndromes on zero data: no column, weight eight, first and last data column.
        queue_cmd(ACTION_CHECK, {64'h0, 8'h03}, 0);
        queue_cmd(ACTION_CHECK, {64'h0, 8'hFF}, 0);
        queue_cmd(ACTION_CHECK, {64'h0, 8'h07}, 0);
        queue_cmd(ACTION_CHECK, {64'h0, 8'h8F}, 0);

        // Random: four phases of sender idling, with idle-free bursts inside.
        no_idle = 1'b0;
        for (int i = 0; i < 600; i++)
        begin
            if (i % 25 == 0)
                no_idle = ($urandom_range(3) == 0);
            case (i / 150)
                1:       idle_pct = 64;
                3:       idle_pct = 17;
                default: idle_pct = 0;
            endcase
            if (no_idle)
                idle_pct = 0;
            cw   = valid_codeword({$urandom, $urandom});
            kind = $urandom_range(19);
            if (kind < 5)
            begin
                cw[7:0] = 8'($urandom_range(255));
                queue_cmd(ACTION_ENCODE, cw, idle_pct);
            end
            else
            begin
                p1 = $urandom_range(72, 1);
                p2 = $urandom_range(72, 1);
                while (p2 == p1)
                    p2 = $urandom_range(72, 1);
                if (kind < 9)
                    queue_cmd(ACTION_CHECK, cw, idle_pct);
                else if (kind < 15)
                    queue_cmd(ACTION_CHECK, flip_position(cw, p1), idle_pct);
                else if (kind < 18)
                    queue_cmd(ACTION_CHECK, flip_position(flip_position(cw, p1), p2),
                              idle_pct);
                else
                begin
                    // Noise: random check byte against random data.
                    cw[7:0] = 8'($urandom_range(255));
                    queue_cmd(ACTION_CHECK, cw, idle_pct);
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || start)
            @(posedge clk);
        while (expected_words.size() > 0)
            @(posedge clk);
        // Drain: catch any stray result strobes.
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/secded_pkg.sv
rtl/secded_parity.sv
rtl/secded_correct.sv
rtl/secded_72_64_encode_correct.sv
tb/secded_72_64_encode_correct_test.sv
